/* src/buddy_block_allocator_unit_assert.svh */
// Assertion macros used by the buddy allocator controller.
// Each macro expects signals named clk and rst in the using scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the buddy allocator controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W = 64;
  localparam int ORD_W  = 6;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_POOL_BASE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_POOL_LOG  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BLK_LOG   = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [ORD_W-1:0] POOL_LOG_RST = 6'd14;
  localparam logic [ORD_W-1:0] BLK_LOG_RST  = 6'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RS_HEAD,
    RS_ID,
    RS_BUDDY
  } rsel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_AUNLINK,
    S_SPLIT,
    S_PUSH1,
    S_PUSH2,
    S_FRD,
    S_FTAG,
    S_BRD,
    S_BEVAL,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    clear_step;
    logic    k_want;
    logic    k_inc;
    logic    k_dec;
    logic    id_rel;
    logic    id_head;
    logic    id_merge;
    logic    hid_half;
    logic    hid_id;
    rsel_t   rsel;
    logic    unlink;
    logic    unlink_buddy;
    logic    push1;
    logic    push2;
    logic    set_status;
    status_t code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_bad;
    logic addr_bad;
    logic head_nil;
    logic k_lt_top;
    logic k_gt_want;
    logic tag_set;
    logic merge_ok;
    logic clr_last;
    logic out_busy;
  } dp_sts_t;

endpackage

/* src/bba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Configuration registers, free-list heads, block tag and link memories,
// request registers and the result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int LOG_BLOCKS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bba_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_data,
  input  logic                        action,
  input  logic [bba_pkg::ORD_W-1:0]   size_order,
  input  logic [bba_pkg::ADDR_W-1:0]  block_address,
  input  bba_pkg::dp_cmd_t            cmd,
  output bba_pkg::dp_sts_t            sts,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [bba_pkg::ADDR_W-1:0]  granted_address,
  output bba_pkg::status_t            status
);
  import bba_pkg::*;

  localparam int MAX_BLOCKS = 1 << LOG_BLOCKS;
  localparam int IW = LOG_BLOCKS;
  localparam int LW = LOG_BLOCKS + 1;
  localparam int OW = $clog2(LOG_BLOCKS + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

  logic [ADDR_W-1:0] pool_base;
  logic [ORD_W-1:0]  pool_log;
  logic [ORD_W-1:0]  blk_log;

  logic              act_r;
  logic              req_bad;
  logic [ORD_W-1:0]  abs_order;
  logic [OW-1:0]     want;
  logic [OW-1:0]     top;
  logic [ADDR_W-1:0] rel;
  logic [OW-1:0]     k;
  logic [IW-1:0]     id;
  logic [IW-1:0]     hid;
  logic [LW-1:0]     h_r;
  logic [IW-1:0]     clr;
  status_t           res_status;

  logic [LW-1:0] head [LOG_BLOCKS+1];
  logic [OW:0]   tag_mem  [MAX_BLOCKS];
  logic [LW-1:0] next_mem [MAX_BLOCKS];
  logic [LW-1:0] prev_mem [MAX_BLOCKS];
  logic [OW:0]   tag_rd;
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;

  logic             order_lo;
  logic [ORD_W-1:0] span;
  logic             load_bad;
  logic [IW-1:0]    buddy;
  logic [IW-1:0]    half;
  logic [IW-1:0]    raddr;
  logic             p_nil;
  logic             n_nil;
  logic             tag_we;
  logic [IW-1:0]    tag_wa;
  logic [OW:0]      tag_wd;
  logic             next_we;
  logic [IW-1:0]    next_wa;
  logic [LW-1:0]    next_wd;
  logic             prev_we;
  logic [IW-1:0]    prev_wa;
  logic [LW-1:0]    prev_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_log  <= POOL_LOG_RST;
      blk_log   <= BLK_LOG_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POOL_BASE: pool_base <= cfg_data;
        REG_POOL_LOG:  pool_log  <= cfg_data[ORD_W-1:0];
        REG_BLK_LOG:   blk_log   <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign order_lo = size_order < blk_log;
  assign span     = pool_log - blk_log;
  assign load_bad = (blk_log > pool_log) || (span > ORD_W'(LOG_BLOCKS))
                    || (size_order > pool_log);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= action;
      req_bad   <= load_bad;
      top       <= OW'(span);
      want      <= order_lo ? '0 : OW'(size_order - blk_log);
      abs_order <= order_lo ? blk_log : size_order;
      rel       <= block_address - pool_base;
    end
  end

  assign buddy = id ^ (IW'(1) << k);
  assign half  = id + (IW'(1) << (k - OW'(1)));

  always_ff @(posedge clk) begin
    if (cmd.k_want) begin
      k <= want;
    end else if (cmd.k_inc) begin
      k <= k + OW'(1);
    end else if (cmd.k_dec) begin
      k <= k - OW'(1);
    end
    if (cmd.id_rel) begin
      id <= IW'(rel >> blk_log);
    end else if (cmd.id_head) begin
      id <= head[k][IW-1:0];
    end else if (cmd.id_merge) begin
      id <= (buddy < id) ? buddy : id;
    end
    if (cmd.hid_half) begin
      hid <= half;
    end else if (cmd.hid_id) begin
      hid <= id;
    end
    if (cmd.push1) begin
      h_r <= head[k];
    end
    if (cmd.set_status) begin
      res_status <= cmd.code;
    end
  end

  always_comb begin
    case (cmd.rsel)
      RS_HEAD:  raddr = head[k][IW-1:0];
      RS_ID:    raddr = id;
      RS_BUDDY: raddr = buddy;
      default:  raddr = id;
    endcase
  end

  assign p_nil = prev_rd == NIL;
  assign n_nil = next_rd == NIL;

  always_comb begin
    tag_we = cmd.clear_step || cmd.unlink || cmd.push1;
    if (cmd.clear_step) begin
      tag_wa = clr;
    end else if (cmd.push1) begin
      tag_wa = hid;
    end else begin
      tag_wa = cmd.unlink_buddy ? buddy : id;
    end
    tag_wd = cmd.push1 ? {1'b1, k} : '0;

    next_we = (cmd.unlink && !p_nil) || cmd.push1;
    next_wa = cmd.push1 ? hid : prev_rd[IW-1:0];
    next_wd = cmd.push1 ? head[k] : next_rd;

    prev_we = (cmd.unlink && !n_nil) || cmd.push1 || (cmd.push2 && h_r != NIL);
    if (cmd.push1) begin
      prev_wa = hid;
      prev_wd = NIL;
    end else if (cmd.push2) begin
      prev_wa = h_r[IW-1:0];
      prev_wd = LW'(hid);
    end else begin
      prev_wa = next_rd[IW-1:0];
      prev_wd = prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    tag_rd  <= tag_mem[raddr];
    next_rd <= next_mem[raddr];
    prev_rd <= prev_mem[raddr];
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LOG_BLOCKS; i++) begin
        head[i] <= NIL;
      end
    end else if (cmd.unlink && p_nil) begin
      head[k] <= next_rd;
    end else if (cmd.push1) begin
      head[k] <= LW'(hid);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_step) begin
      clr <= clr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      granted_address <= (act_r == ACT_ALLOC && res_status == ST_OK)
                         ? pool_base + (ADDR_W'(id) << blk_log) : '0;
    end
  end

  always_comb begin
    sts.is_free   = act_r == ACT_FREE;
    sts.req_bad   = req_bad;
    sts.addr_bad  = ((rel >> pool_log) != '0)
                    || ((rel & ((64'd1 << abs_order) - 64'd1)) != '0);
    sts.head_nil  = head[k] == NIL;
    sts.k_lt_top  = k < top;
    sts.k_gt_want = k > want;
    sts.tag_set   = tag_rd[OW];
    sts.merge_ok  = tag_rd[OW] && (tag_rd[OW-1:0] == k);
    sts.clr_last  = clr == IW'(MAX_BLOCKS - 1);
    sts.out_busy  = out_valid && out_stall;
  end

endmodule

/* src/bba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate (scan, unlink, split) and free (check, merge, push).
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bba_pkg::dp_sts_t sts,
  output bba_pkg::dp_cmd_t cmd
);
  import bba_pkg::*;

  `include "buddy_block_allocator_unit_assert.svh"

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (sts.req_bad) state_next = S_DONE;
        else if (!sts.is_free) state_next = S_SCAN;
        else if (sts.addr_bad) state_next = S_DONE;
        else state_next = S_FRD;
      end
      S_SCAN: begin
        if (!sts.head_nil) state_next = S_AUNLINK;
        else if (!sts.k_lt_top) state_next = S_DONE;
      end
      S_AUNLINK: state_next = sts.k_gt_want ? S_SPLIT : S_DONE;
      S_SPLIT:   state_next = S_PUSH1;
      S_PUSH1:   state_next = S_PUSH2;
      S_PUSH2:   state_next = (!sts.is_free && sts.k_gt_want) ? S_SPLIT : S_DONE;
      S_FRD:     state_next = S_FTAG;
      S_FTAG:    state_next = sts.tag_set ? S_DONE : S_BRD;
      S_BRD:     state_next = sts.k_lt_top ? S_BEVAL : S_PUSH1;
      S_BEVAL:   state_next = sts.merge_ok ? S_BRD : S_PUSH1;
      S_DONE:    if (!sts.out_busy) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rsel = RS_ID;
    cmd.code = ST_OK;
    in_stall = state != S_IDLE;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_CHECK: begin
        cmd.k_want = 1'b1;
        if (sts.req_bad) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_BAD_ORDER;
        end else if (sts.is_free && sts.addr_bad) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_BAD_FREE;
        end else if (sts.is_free) begin
          cmd.id_rel = 1'b1;
        end
      end
      S_SCAN: begin
        if (!sts.head_nil) begin
          cmd.id_head = 1'b1;
          cmd.rsel    = RS_HEAD;
        end else if (sts.k_lt_top) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_NO_FREE;
        end
      end
      S_AUNLINK: begin
        cmd.unlink     = 1'b1;
        cmd.set_status = !sts.k_gt_want;
      end
      S_SPLIT: begin
        cmd.k_dec    = 1'b1;
        cmd.hid_half = 1'b1;
      end
      S_PUSH1: cmd.push1 = 1'b1;
      S_PUSH2: begin
        cmd.push2      = 1'b1;
        cmd.set_status = sts.is_free || !sts.k_gt_want;
      end
      S_FRD: cmd.rsel = RS_ID;
      S_FTAG: begin
        if (sts.tag_set) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_BAD_FREE;
        end
      end
      S_BRD: begin
        if (sts.k_lt_top) cmd.rsel = RS_BUDDY;
        else cmd.hid_id = 1'b1;
      end
      S_BEVAL: begin
        if (sts.merge_ok) begin
          cmd.unlink       = 1'b1;
          cmd.unlink_buddy = 1'b1;
          cmd.id_merge     = 1'b1;
          cmd.k_inc        = 1'b1;
        end else begin
          cmd.hid_id = 1'b1;
        end
      end
      S_DONE: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  `BBA_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state == S_CHECK,
    "accepted item did not enter the check step")
  `BBA_ASSERT_NEXT(a_merge_loop, state == S_BEVAL && sts.merge_ok, state == S_BRD,
    "merge did not continue with the next buddy")
  `BBA_ASSERT_NOW(a_clear_quiet, state == S_CLEAR, in_stall && !cmd.out_load && !cmd.load,
    "activity during the clearing pass")

endmodule

/* src/buddy_block_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator with per-order doubly linked free lists.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall) carries action, size_order and
//   block_address; an item is taken when in_valid is high and in_stall low.
//   Result channel (out_valid/out_stall) returns granted_address and status,
//   one item per request, held in an output register until taken.
//   Config writes (cfg_write, cfg_index, cfg_data) go in while idle.
//   After reset a clearing pass walks the tag memory, one block a cycle;
//   in_stall stays high meanwhile. All blocks then count as allocated and
//   all lists are empty. Allocate scans the lists up from the wanted order,
//   unlinks one block and splits it level by level; free checks the tag,
//   then merges with its buddy level by level up to the pool order. A bad
//   order or address, a double free or no free block ends a request with
//   an error status. Each link memory has one read and one write port: one
//   list update step per cycle. One request is in work at a time; the next
//   is taken the cycle after the result is loaded. A stalled receiver holds
//   the result and the block waits before loading the next one.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
  parameter int LOG_BLOCKS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bba_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [bba_pkg::ORD_W-1:0]  size_order,
  input  logic [bba_pkg::ADDR_W-1:0] block_address,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bba_pkg::ADDR_W-1:0] granted_address,
  output logic [1:0]                 status
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_t status_q;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath #(
    .LOG_BLOCKS (LOG_BLOCKS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .size_order      (size_order),
    .block_address   (block_address),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .granted_address (granted_address),
    .status          (status_q)
  );

  assign status = status_q;

endmodule

/* bench/tb_buddy_block_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_unit
// Self-checking bench for the buddy allocator: a software copy of the free
// lists predicts each grant and status; requests mix well-formed alloc/free
// sequences with malformed frees and bad orders across several pool settings.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_unit;
  import bba_pkg::*;

  class alloc_scoreboard;
    localparam int NB   = 1024;
    localparam int NIL  = 1024;
    localparam int LOGB = 10;
    localparam int MASK = NB - 1;

    bit [63:0] base;
    bit [5:0]  porder;
    bit [5:0]  morder;
    bit        tag[NB];
    bit [5:0]  bord[NB];
    int        nxt[NB];
    int        prv[NB];
    int        head[LOGB+1];
    bit [63:0] exp_addr[$];
    status_t   exp_st[$];
    int        errors;

    function new();
      base = 0;
      porder = POOL_LOG_RST;
      morder = BLK_LOG_RST;
      errors = 0;
      foreach (tag[i]) tag[i] = 0;
      foreach (head[i]) head[i] = NIL;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, bit [63:0] v);
      case (idx)
        REG_POOL_BASE: base = v;
        REG_POOL_LOG:  porder = v[5:0];
        REG_BLK_LOG:   morder = v[5:0];
        default: ;
      endcase
    endfunction

    function bit cfg_ok();
      return !(morder > porder || porder - morder > LOGB);
    endfunction

    function int pending();
      return exp_st.size();
    endfunction

    function void unlink(int id, int k);
      int p;
      int n;
      p = prv[id];
      n = nxt[id];
      if (p == NIL) head[k] = n;
      else nxt[p & MASK] = n;
      if (n != NIL) prv[n & MASK] = p;
    endfunction

    function void push(int id, int k);
      int h;
      h = head[k];
      nxt[id] = h;
      prv[id] = NIL;
      if (h != NIL) prv[h & MASK] = id;
      head[k] = id;
      bord[id] = k[5:0];
      tag[id] = 1;
    endfunction

    function void note_request(logic act, bit [5:0] ord, bit [63:0] addr,
                               output bit [63:0] ga, output status_t st);
      int top;
      int want;
      int k;
      int id;
      int buddy;
      int abs_o;
      bit found;
      bit [63:0] rel;
      ga = 0;
      st = ST_OK;
      if (!cfg_ok() || ord > porder) begin
        st = ST_BAD_ORDER;
      end else begin
        top = porder - morder;
        want = (ord < morder) ? 0 : ord - morder;
        if (act == ACT_ALLOC) begin
          st = ST_NO_FREE;
          found = 0;
          k = want;
          while (!found && k <= top) begin
            if (head[k] != NIL) begin
              found = 1;
              id = head[k] & MASK;
              unlink(id, k);
              tag[id] = 0;
              while (k > want) begin
                k--;
                push((id + (1 << k)) & MASK, k);
              end
              ga = base + (64'(id) << morder);
              st = ST_OK;
            end else begin
              k++;
            end
          end
        end else begin
          rel = addr - base;
          abs_o = want + morder;
          if ((rel >> porder) != 0 || (rel & ((64'd1 << abs_o) - 64'd1)) != 0) begin
            st = ST_BAD_FREE;
          end else begin
            id = int'(rel >> morder) & MASK;
            if (tag[id]) begin
              st = ST_BAD_FREE;
            end else begin
              k = want;
              // merge upward while the buddy heads a free block of equal order
              while (k < top) begin
                buddy = (id ^ (1 << k)) & MASK;
                if (!tag[buddy] || bord[buddy] != k) break;
                unlink(buddy, k);
                tag[buddy] = 0;
                if (buddy < id) id = buddy;
                k++;
              end
              push(id, k);
            end
          end
        end
      end
      exp_addr.push_back(ga);
      exp_st.push_back(st);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(bit [63:0] ga, status_t st);
      bit [63:0] ea;
      status_t es;
      if (exp_st.size() == 0) begin
        report($sformatf("unexpected item addr=%h status=%0d", ga, st));
      end else begin
        ea = exp_addr.pop_front();
        es = exp_st.pop_front();
        if (st != es) report($sformatf("status got %0d want %0d", st, es));
        if (ga != ea) report($sformatf("granted_address got %h want %h", ga, ea));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CIDX_W-1:0]   cfg_index;
  logic [ADDR_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                action;
  logic [ORD_W-1:0]    size_order;
  logic [ADDR_W-1:0]   block_address;
  logic                out_valid;
  logic                out_stall;
  logic [ADDR_W-1:0]   granted_address;
  logic [1:0]          status;

  alloc_scoreboard sb;
  bit [63:0] held_addr[$];
  int        held_ord[$];
  int        snd_pct;
  int        rcv_pct;
  bit        hold_req;

  buddy_block_allocator_unit #(.LOG_BLOCKS(10)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .size_order(size_order), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted_address(granted_address), .status(status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else begin
        out_stall <= ($urandom % 100) < rcv_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(granted_address, status_t'(status));
  end

  task send(logic act, bit [5:0] ord, bit [63:0] addr);
    bit [63:0] ga;
    status_t st;
    @(negedge clk);
    while (($urandom % 100) < snd_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    action <= act;
    size_order <= ord;
    block_address <= addr;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, ord, addr, ga, st);
    if (act == ACT_ALLOC && st == ST_OK) begin
      held_addr.push_back(ga);
      held_ord.push_back((ord < sb.morder) ? sb.morder : ord);
    end
  endtask

  task free_held();
    int idx;
    int o;
    bit [63:0] a;
    if (held_addr.size() == 0) begin
      send(ACT_ALLOC, 6'($urandom_range(0, sb.porder)), 64'($urandom));
    end else begin
      idx = $urandom_range(0, held_addr.size() - 1);
      a = held_addr[idx];
      o = held_ord[idx];
      held_addr.delete(idx);
      held_ord.delete(idx);
      // an order below the minimum is raised by the block, so it frees the same
      if (o == sb.morder && ($urandom % 4) == 0) o = $urandom_range(0, o);
      send(ACT_FREE, 6'(o), a);
    end
  endtask

  task random_item();
    int r;
    r = $urandom % 100;
    if (r < 45) begin
      if (($urandom % 20) == 0)
        send(ACT_ALLOC, 6'($urandom_range(0, 63)), {$urandom, $urandom});
      else send(ACT_ALLOC, 6'($urandom_range(0, sb.porder)), {$urandom, $urandom});
    end else if (r < 85) begin
      free_held();
    end else begin
      send(ACT_FREE, 6'($urandom_range(0, 63)), {$urandom, $urandom});
    end
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task set_regs(bit [63:0] b, bit [5:0] po, bit [5:0] mo);
    bit [63:0] v[3];
    v[0] = b;
    v[1] = {$urandom, $urandom};
    v[1][5:0] = po;
    v[2] = {$urandom, $urandom};
    v[2][5:0] = mo;
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_write <= 1;
      cfg_index <= i[CIDX_W-1:0];
      cfg_data <= v[i];
      sb.write_reg(i[CIDX_W-1:0], v[i]);
    end
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // return every block, then take the whole pool so the next setting starts empty
  task teardown();
    while (held_addr.size() > 0) free_held();
    if (sb.cfg_ok()) begin
      send(ACT_ALLOC, sb.porder, 0);
      held_addr.delete();
      held_ord.delete();
    end
  endtask

  initial begin
    bit [63:0] ph_base[7];
    int ph_po[7];
    int ph_mo[7];
    int ph_n[7];
    sb = new();
    hold_req = 0;
    snd_pct = 35;
    rcv_pct = 45;
    rst = 1;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    action = 0;
    size_order = 0;
    block_address = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset setting, pool of 16 KiB in 16-byte blocks
    send(ACT_ALLOC, 0, 0);
    send(ACT_ALLOC, 63, 0);
    send(ACT_FREE, 63, 0);
    send(ACT_FREE, 4, 64'h4000);
    send(ACT_FREE, 4, 64'h8);
    send(ACT_FREE, 4, 64'hFFFF_FFFF_FFFF_FFF0);
    send(ACT_FREE, 14, 0);
    send(ACT_FREE, 14, 0);
    send(ACT_ALLOC, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(ACT_ALLOC, 14, 0);
    send(ACT_ALLOC, 4, 0);
    send(ACT_ALLOC, 13, 0);
    send(ACT_ALLOC, 5, 0);
    send(ACT_FREE, 4, 64'h10);
    send(ACT_FREE, 4, 64'h10);
    while (held_addr.size() > 0) free_held();
    send(ACT_ALLOC, 14, 0);
    free_held();
    for (int i = 0; i < 15; i++) random_item();
    hold_req = 1;
    for (int i = 0; i < 10; i++) random_item();
    teardown();
    drain();

    ph_base = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 64'd0, {$urandom, $urandom}};
    ph_po = '{20, 63, 0, 63, 5, 16, 12};
    ph_mo = '{10, 60, 0, 53, 9, 5, 6};
    ph_n  = '{120, 60, 20, 100, 15, 15, 120};
    for (int p = 0; p < 7; p++) begin
      if (p == 2) begin
        snd_pct = 45;
        rcv_pct = 35;
      end else if (p == 4) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      set_regs(ph_base[p], 6'(ph_po[p]), 6'(ph_mo[p]));
      if (sb.cfg_ok()) send(ACT_FREE, 6'(ph_po[p]), ph_base[p]);
      for (int i = 0; i < ph_n[p]; i++) begin
        if (i == ph_n[p] / 2) begin
          if (p == 0) hold_req = 1;
          if (p == 3) drain();
        end
        random_item();
      end
      teardown();
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
